// File: sv/poa_pkg.sv
// ----------------------------------------------------------------------------
// poa_pkg: shared types and constants for the patch overlap averager
// Sample and sum widths, operation codes, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package poa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int STEP_W   = $clog2(SUM_W);
  localparam int CFG_W    = 9;
  localparam int PATCH_W  = 5;
  localparam int IDX_W    = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_PATCH_ROWS   = 2'd2;
  localparam logic [IDX_W-1:0] REG_PATCH_COLS   = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // write zero at the clearing address, advance it
    logic ld_take;  // load transaction accepted
    logic rd_take;  // read transaction accepted
    logic mem_rd;   // read the store at the current address
    logic wr_sum;   // write back the updated sum
    logic wr_zero;  // clear the pixel just read
    logic div_go;   // start the divider
    logic emit;     // present the result
  } poa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic load_ok;
    logic div_done;
  } poa_sts_t;

endpackage

// File: sv/patch_overlap_average.sv
// ----------------------------------------------------------------------------
// patch_overlap_average: overlap-averaging image rebuild from stride-1 patches
// Accumulates patch elements into a per-pixel sum store and reads pixels
// back in raster order, each divided by the number of patches covering it.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+---------------------------
//  command  | start, busy, op, sample              | taken when start & !busy
//  result   | done, pixel, last_pixel              | done high for one cycle
//  config   | cfg_write, cfg_index, cfg_data       | written when cfg_write
//
// Sequence: a load holds busy after acceptance while it reads, then writes
//   back on the single store port; no command is taken meanwhile. A read
//   holds busy through the store read and clear, the bit-serial divider and
//   the result.
// Loads that fall outside the patch grid are dropped and leave busy low.
// Reset: synchronous; after it the store is cleared one entry per cycle,
//   all MAX_WIDTH*MAX_HEIGHT entries (65536 by default); busy stays high.
// Stalls: the receiver cannot stall; each result shows for one cycle only.
// Config writes restart all position counters and keep the stored sums.
// ----------------------------------------------------------------------------
module patch_overlap_average
  import poa_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_PATCH  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // command transaction
  input  logic                       start,
  output logic                       busy,
  input  logic                       op,
  input  logic signed [SAMPLE_W-1:0] sample,
  // result transaction
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] pixel,
  output logic                       last_pixel,
  // register writes
  input  logic                       cfg_write,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  poa_cmd_t cmd;
  poa_sts_t sts;

  // Sequence the store port and the divider
  poa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold counters, sums and the divider
  poa_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_PATCH  (MAX_PATCH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .cmd        (cmd),
    .sts        (sts),
    .pixel      (pixel),
    .last_pixel (last_pixel)
  );

  // Strobe the result for exactly one cycle
  assign done = cmd.emit;

endmodule

// File: sv/poa_store.sv
// ----------------------------------------------------------------------------
// poa_store: single-port sum store
// One read or one write per cycle, registered read data.
// ----------------------------------------------------------------------------
module poa_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: sv/poa_div.sv
// ----------------------------------------------------------------------------
// poa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, SUM_W quotient bits in all.
// ----------------------------------------------------------------------------
module poa_div
  import poa_pkg::*;
#(
  parameter int DW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DW-1:0]     rem;
  logic [DW:0]       shifted;
  logic [DW+1:0]     diff;
  logic              fits;
  logic [DW-1:0]     rem_next;

  always_comb begin
    shifted  = {rem, quotient[SUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, divisor};
    fits     = !diff[DW+1];
    rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= rem_next;
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

// File: sv/poa_ctrl.sv
// ----------------------------------------------------------------------------
// poa_ctrl: sequencing state machine
// Clears the store after reset, then runs load and read transactions.
// ----------------------------------------------------------------------------
module poa_ctrl
  import poa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     op,
  input  poa_sts_t sts,
  output poa_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_RD_RD, S_RD_CLR, S_DIV, S_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (op == OP_READ) state_next = S_RD_RD;
          else if (sts.load_ok) state_next = S_LD_RD;
        end
      end
      S_LD_RD:  state_next = S_LD_WR;
      S_LD_WR:  state_next = S_IDLE;
      S_RD_RD:  state_next = S_RD_CLR;
      S_RD_CLR: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.clr_wr  = (state == S_CLEAR);
    cmd.ld_take = (state == S_IDLE) && start && (op == OP_LOAD) && sts.load_ok;
    cmd.rd_take = (state == S_IDLE) && start && (op == OP_READ);
    cmd.mem_rd  = (state == S_LD_RD) || (state == S_RD_RD);
    cmd.wr_sum  = (state == S_LD_WR);
    cmd.wr_zero = (state == S_RD_CLR);
    cmd.div_go  = (state == S_RD_CLR);
    cmd.emit    = (state == S_OUT);
  end

  assign busy = (state != S_IDLE);

  a_emit_single: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit)
    else $error("result strobe held for more than one cycle");

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mem_rd, cmd.wr_sum, cmd.wr_zero, cmd.clr_wr}))
    else $error("store port driven by two commands");

  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_done) |=> cmd.emit)
    else $error("quotient ready but no result emitted");

  a_take_needs_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_take || cmd.rd_take) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

// File: sv/poa_dp.sv
// ----------------------------------------------------------------------------
// poa_dp: datapath of the patch overlap averager
// Configuration, load and read counters, cover counts, sum store and divider.
// ----------------------------------------------------------------------------
module poa_dp
  import poa_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_PATCH  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  poa_cmd_t                   cmd,
  output poa_sts_t                   sts,
  output logic signed [SAMPLE_W-1:0] pixel,
  output logic                       last_pixel
);

  localparam int WVW   = $clog2(MAX_WIDTH + 1);
  localparam int HVW   = $clog2(MAX_HEIGHT + 1);
  localparam int PVW   = $clog2(MAX_PATCH + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = 2 * PVW;

  function automatic int cover_count(input int c, input int len, input int npos);
    int lo;
    int hi;
    if (npos == 0) return 0;
    lo = (c + 1 >= len) ? c + 1 - len : 0;
    hi = (c < npos - 1) ? c : npos - 1;
    return (hi >= lo) ? hi - lo + 1 : 0;
  endfunction

  logic [CFG_W-1:0]   cfg_w, cfg_h;
  logic [PATCH_W-1:0] cfg_pr, cfg_pc;
  logic [WVW-1:0]     w, nx, patch_x, rx;
  logic [HVW-1:0]     h, ny, patch_y, ry;
  logic [PVW-1:0]     pr, pc, elem_x, elem_y, cov_x, cov_y;
  logic [PVW-1:0]     cov_x_next, cov_y_next;
  logic [AW-1:0]      read_ptr, cur_addr, ld_addr, clr_addr, st_addr;
  logic [CNTW-1:0]    cnt;
  logic [SUM_W-1:0]   sample_ext, rdata, wdata, mag;
  logic [SUM_W-1:0]   quo;
  logic               sum_neg, div_done, rd_last, st_we;
  logic signed [SAMPLE_W-1:0] pixel_next;

  // Clamp the raw registers into their legal ranges
  always_comb begin
    if (cfg_w == '0) w = WVW'(1);
    else if (32'(cfg_w) > MAX_WIDTH) w = WVW'(MAX_WIDTH);
    else w = WVW'(cfg_w);
    if (cfg_h == '0) h = HVW'(1);
    else if (32'(cfg_h) > MAX_HEIGHT) h = HVW'(MAX_HEIGHT);
    else h = HVW'(cfg_h);
    if (cfg_pr == '0) pr = PVW'(1);
    else if (32'(cfg_pr) > MAX_PATCH) pr = PVW'(MAX_PATCH);
    else pr = PVW'(cfg_pr);
    if (cfg_pc == '0) pc = PVW'(1);
    else if (32'(cfg_pc) > MAX_PATCH) pc = PVW'(MAX_PATCH);
    else pc = PVW'(cfg_pc);
    nx = (32'(pc) <= 32'(w)) ? WVW'(32'(w) - 32'(pc) + 1) : '0;
    ny = (32'(pr) <= 32'(h)) ? HVW'(32'(h) - 32'(pr) + 1) : '0;
  end

  always_comb begin
    sts.load_ok = (nx != '0) && (ny != '0) && (patch_y < ny) && (patch_x < nx)
                  && (elem_y < pr) && (elem_x < pc);
    ld_addr     = AW'((32'(patch_y) + 32'(elem_y)) * 32'(w)
                      + 32'(patch_x) + 32'(elem_x));
    cov_x_next  = PVW'(cover_count(32'(rx), 32'(pc), 32'(nx)));
    cov_y_next  = PVW'(cover_count(32'(ry), 32'(pr), 32'(ny)));
    sts.clr_last = (clr_addr == AW'(DEPTH - 1));
    sts.div_done = div_done;
  end

  // Configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= CFG_W'(256);
      cfg_h    <= CFG_W'(256);
      cfg_pr   <= PATCH_W'(8);
      cfg_pc   <= PATCH_W'(8);
      patch_x  <= '0;
      patch_y  <= '0;
      elem_x   <= '0;
      elem_y   <= '0;
      rx       <= '0;
      ry       <= '0;
      read_ptr <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_wr) clr_addr <= clr_addr + 1'b1;
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  cfg_w  <= cfg_data;
          REG_IMAGE_HEIGHT: cfg_h  <= cfg_data;
          REG_PATCH_ROWS:   cfg_pr <= cfg_data[PATCH_W-1:0];
          REG_PATCH_COLS:   cfg_pc <= cfg_data[PATCH_W-1:0];
          default: ;
        endcase
        patch_x  <= '0;
        patch_y  <= '0;
        elem_x   <= '0;
        elem_y   <= '0;
        rx       <= '0;
        ry       <= '0;
        read_ptr <= '0;
      end else if (cmd.ld_take) begin
        if (32'(elem_x) + 1 == 32'(pc)) begin
          elem_x <= '0;
          if (32'(elem_y) + 1 == 32'(pr)) begin
            elem_y <= '0;
            if (32'(patch_x) + 1 == 32'(nx)) begin
              patch_x <= '0;
              patch_y <= patch_y + 1'b1;
            end else begin
              patch_x <= patch_x + 1'b1;
            end
          end else begin
            elem_y <= elem_y + 1'b1;
          end
        end else begin
          elem_x <= elem_x + 1'b1;
        end
      end else if (cmd.rd_take) begin
        if (rd_last) begin
          patch_x  <= '0;
          patch_y  <= '0;
          elem_x   <= '0;
          elem_y   <= '0;
          rx       <= '0;
          ry       <= '0;
          read_ptr <= '0;
        end else begin
          read_ptr <= read_ptr + 1'b1;
          if (32'(rx) + 1 == 32'(w)) begin
            rx <= '0;
            ry <= ry + 1'b1;
          end else begin
            rx <= rx + 1'b1;
          end
        end
      end
    end
  end

  assign rd_last = (32'(rx) + 1 == 32'(w)) && (32'(ry) + 1 == 32'(h));

  // Per-transaction payload
  always_ff @(posedge clk) begin
    if (cmd.ld_take) begin
      cur_addr   <= ld_addr;
      sample_ext <= {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    end else if (cmd.rd_take) begin
      cur_addr   <= read_ptr;
      cov_x      <= cov_x_next;
      cov_y      <= cov_y_next;
      last_pixel <= rd_last;
    end
    if (cmd.mem_rd) cnt <= CNTW'(cov_y) * CNTW'(cov_x);
    if (cmd.div_go) sum_neg <= rdata[SUM_W-1];
    if (div_done) pixel <= pixel_next;
  end

  always_comb begin
    st_addr = cmd.clr_wr ? clr_addr : cur_addr;
    st_we   = cmd.clr_wr || cmd.wr_sum || cmd.wr_zero;
    wdata   = cmd.wr_sum ? rdata + sample_ext : '0;
    mag     = rdata[SUM_W-1] ? (~rdata + 1'b1) : rdata;
  end

  // Saturate the signed quotient to 16 bits
  always_comb begin
    if (cnt == '0) begin
      pixel_next = '0;
    end else if (sum_neg) begin
      if (quo > SUM_W'(32768)) pixel_next = 16'sh8000;
      else pixel_next = SAMPLE_W'(~quo[SAMPLE_W-1:0] + 1'b1);
    end else begin
      if (quo > SUM_W'(32767)) pixel_next = 16'sh7FFF;
      else pixel_next = SAMPLE_W'(quo[SAMPLE_W-1:0]);
    end
  end

  poa_store #(.DEPTH(DEPTH), .AW(AW), .DW(SUM_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .re    (cmd.mem_rd),
    .addr  (st_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  poa_div #(.DW(CNTW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (mag),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the patch overlap averager
// Drives load/read commands and register writes, predicts every averaged
// pixel from a behavioral copy of the sum store and counters, and compares
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import poa_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int MAXP = 16;
  localparam int IDLE_LIMIT = 200000;  // covers the post-reset clearing pass

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] pixel;
    logic                       last;
  } pix_t;

  logic clk, rst;
  logic start, op, cfg_write;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic busy, done, last_pixel;
  logic signed [SAMPLE_W-1:0] pixel;

  patch_overlap_average dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .sample(sample),
    .done(done), .pixel(pixel), .last_pixel(last_pixel),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [SUM_W-1:0] sums [MAXW*MAXH];
  int unsigned reg_w, reg_h, reg_pr, reg_pc;
  int unsigned py, px, ey, ex, rptr;

  cmd_t pending_cmds[$];
  pix_t expected_pixels[$];
  int   errors, n_loads, n_reads, n_pixels, n_last, idle_cycles;
  bit   feeding_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return v > hi ? hi : v;
  endfunction

  function automatic int unsigned cover_count(int unsigned c, int unsigned len,
                                              int unsigned npos);
    int unsigned lo, hi;
    if (npos == 0) return 0;
    lo = (c + 1 >= len) ? c + 1 - len : 0;
    hi = (c < npos - 1) ? c : npos - 1;
    return (hi >= lo) ? hi - lo + 1 : 0;
  endfunction

  function automatic void restart_positions();
    py = 0; px = 0; ey = 0; ex = 0; rptr = 0;
  endfunction

  // Apply one accepted transaction to the predictor; queue the expected pixel.
  function automatic void predict_average(cmd_t c);
    int unsigned w, h, pr, pc, nx, ny, total, addr, p, cnt;
    int signed s, q;
    pix_t r;
    w = clampv(reg_w, MAXW); h = clampv(reg_h, MAXH);
    pr = clampv(reg_pr, MAXP); pc = clampv(reg_pc, MAXP);
    nx = (pc <= w) ? w - pc + 1 : 0;
    ny = (pr <= h) ? h - pr + 1 : 0;
    total = w * h;
    if (c.op == OP_LOAD) begin
      if (nx == 0 || ny == 0 || py >= ny || px >= nx || ey >= pr || ex >= pc)
        return;
      addr = (py + ey) * w + (px + ex);
      sums[addr] = sums[addr] + SUM_W'(c.sample);
      ex++;
      if (ex == pc) begin
        ex = 0; ey++;
        if (ey == pr) begin
          ey = 0; px++;
          if (px == nx) begin
            px = 0; py++;
          end
        end
      end
    end else begin
      p = (rptr < total) ? rptr : total - 1;
      cnt = cover_count(p / w, pr, ny) * cover_count(p % w, pc, nx);
      s = signed'({{8{sums[p][SUM_W-1]}}, sums[p]});
      sums[p] = '0;
      q = (cnt != 0) ? s / int'(cnt) : 0;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.pixel = q[SAMPLE_W-1:0];
      r.last = (p == total - 1);
      expected_pixels.push_back(r);
      if (r.last) restart_positions();
      else rptr = p + 1;
    end
  endfunction

  // Driver: hold start until the transaction is taken, then idle at random.
  int gap;
  cmd_t cur;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      if (start && !busy) begin
        predict_average(cur);
        if (cur.op == OP_LOAD) n_loads++; else n_reads++;
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur = pending_cmds.pop_front();
        op <= cur.op;
        sample <= cur.sample;
        start <= 1'b1;
        // mostly back to back, some short gaps, rarely a long one
        case ($urandom_range(0, 9))
          0, 1, 2: gap = $urandom_range(1, 3);
          3:       gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : 0;
          default: gap = 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check every result transaction against the oldest prediction.
  pix_t exp_pix;
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (done) begin
        n_pixels++;
        if (last_pixel) n_last++;
        if (expected_pixels.size() == 0) begin
          report($sformatf("unexpected pixel %0d", pixel));
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel !== exp_pix.pixel)
            report($sformatf("pixel got %0d want %0d", pixel, exp_pix.pixel));
          if (last_pixel !== exp_pix.last)
            report($sformatf("last_pixel got %0b want %0b", last_pixel,
                             exp_pix.last));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push(logic o, logic signed [SAMPLE_W-1:0] s);
    cmd_t c;
    c.op = o; c.sample = s;
    pending_cmds.push_back(c);
  endtask

  // Wait for the queue to drain and all pixels to come back.
  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);  // a trailing load may still be busy
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned v);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  reg_w = v & 9'h1FF;
      REG_IMAGE_HEIGHT: reg_h = v & 9'h1FF;
      REG_PATCH_ROWS:   reg_pr = v & 5'h1F;
      default:          reg_pc = v & 5'h1F;
    endcase
    restart_positions();
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned pr,
                       int unsigned pc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PATCH_ROWS, pr);
    write_reg(REG_PATCH_COLS, pc);
  endtask

  // One full image: all loads (random content, some replaced by reads when noise is set), then all reads.
  task automatic image_pass(int unsigned w, int unsigned h, int unsigned pr,
                            int unsigned pc, int noise);
    int unsigned nl;
    nl = ((pc <= w && pr <= h) ? (w - pc + 1) * (h - pr + 1) * pr * pc : 0);
    for (int i = 0; i < nl; i++) begin
      if (noise > 0 && $urandom_range(0, 99) < noise) push(OP_READ, 'x ^ 'x);
      else push(OP_LOAD, SAMPLE_W'($urandom()));
    end
    for (int i = 0; i < w * h; i++) push(OP_READ, SAMPLE_W'($urandom()));
  endtask

  int unsigned rw, rh, rpr, rpc;
  initial begin
    errors = 0; n_loads = 0; n_reads = 0; n_pixels = 0; n_last = 0;
    idle_cycles = 0;
    start = 0; op = 0; sample = 0; cfg_write = 0; cfg_index = '0; cfg_data = '0;
    foreach (sums[i]) sums[i] = '0;
    reg_w = 256; reg_h = 256; reg_pr = 8; reg_pc = 8;
    restart_positions();
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);  // store clearing pass

    // Directed: extreme samples on the reset geometry, partial read.
    push(OP_LOAD, 16'sh7FFF); push(OP_LOAD, 16'sh8000);
    push(OP_LOAD, 16'sh0000); push(OP_LOAD, 16'shFFFF);
    push(OP_READ, 0); push(OP_READ, 0); push(OP_READ, 16'sh5555);
    drain();
    // Tiny image, extreme samples to exercise saturation/wrap.
    setup(2, 2, 1, 1);
    repeat (4) push(OP_LOAD, 16'sh7FFF);
    repeat (4) push(OP_READ, 0);
    repeat (2) push(OP_LOAD, 16'sh8000);  // loads after the final read start a new image
    drain();
    // Patch larger than image: loads ignored, reads are zero.
    setup(3, 2, 3, 4);
    push(OP_LOAD, 16'sh1234); push(OP_LOAD, 16'shAAAA);
    repeat (6) push(OP_READ, 0);
    drain();
    // Zero and oversize registers clamp.
    setup(0, 0, 0, 0);
    push(OP_LOAD, 16'sh4000); push(OP_READ, 0); push(OP_READ, 0);
    drain();
    setup(511, 1, 31, 31);  // width 256, height 1, patch 16x16: no positions
    drain();

    // Random phases with small geometries; one of them is large-ish.
    for (int ph = 0; ph < 20; ph++) begin
      rw = $urandom_range(1, 6); rh = $urandom_range(1, 5);
      rpr = $urandom_range(1, 3); rpc = $urandom_range(1, 4);
      if (ph == 3) begin rpr = 16; rpc = 16; rw = 16; rh = 17; end
      setup(rw, rh, rpr, rpc);
      image_pass(rw, rh, rpr, rpc, (ph % 3 == 2) ? 10 : 0);
      if (ph % 4 == 1) repeat ($urandom_range(1, 5)) push(OP_LOAD, SAMPLE_W'($urandom()));
      drain();
    end

    $display("Covered %0d loads and %0d reads; %0d pixels checked, %0d image ends.",
             n_loads, n_reads, n_pixels, n_last);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
